[rtl/ttb_pkg.sv]
// ----------------------------------------------------------------------------
// ttb_pkg: shared types and constants for the triangle tangent basis block
// Holds the sequencer states, the multiplier control word and the fixed
// widths of the Q15.16 result format.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ttb_pkg;

    // Result word format: signed Q15.16.
    localparam int OUT_W  = 32;
    localparam int Q_FRAC = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC_GO,
        ST_MAC_WAIT,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic start;
        logic clear;
        logic sub;
    } mac_ctrl_t;

endpackage

`default_nettype wire

[rtl/triangle_tangent_basis.sv]
// ----------------------------------------------------------------------------
// triangle_tangent_basis: per-triangle tangent and bitangent from UVs
// First two corners are held; the third starts a serial multiply and divide.
// ----------------------------------------------------------------------------
// Corners one and two are each held as they are taken. The third corner
// starts fourteen bit-serial products, then six restoring divisions, then
// the load of the output word. A degenerate triangle ends after the
// determinant. Reset clears the corner count and the output valid flag;
// the output word and held corners are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module triangle_tangent_basis #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic signed [COORD_BITS-1:0] pos_x,
    input  wire logic signed [COORD_BITS-1:0] pos_y,
    input  wire logic signed [COORD_BITS-1:0] pos_z,
    input  wire logic signed [COORD_BITS-1:0] tex_u,
    input  wire logic signed [COORD_BITS-1:0] tex_v,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic signed [31:0]                tangent_x,
    output logic signed [31:0]                tangent_y,
    output logic signed [31:0]                tangent_z,
    output logic signed [31:0]                bitangent_x,
    output logic signed [31:0]                bitangent_y,
    output logic signed [31:0]                bitangent_z,
    output logic                              degenerate
);

    localparam int C  = COORD_BITS;
    localparam int D  = C + 1;
    localparam int W  = 2 * C + 2;
    localparam int QW = ttb_pkg::OUT_W;

    ttb_pkg::state_t state_reg, state_next;

    logic [1:0]          count_reg, count_next;
    logic [2:0]          k_reg, k_next;
    logic                ph_reg, ph_next;
    logic                degen_reg, degen_next;
    logic                ov_reg, ov_next;

    logic signed [C-1:0] h0_reg [5];
    logic signed [C-1:0] h1_reg [5];
    logic signed [C-1:0] cur [5];
    logic signed [D-1:0] dp1_reg [3];
    logic signed [D-1:0] dp2_reg [3];
    logic signed [D-1:0] du1_reg, dv1_reg, du2_reg, dv2_reg;
    logic signed [W-1:0] det_reg;
    logic [QW-1:0]       res_reg [6];
    logic [QW-1:0]       ow_reg [6];

    logic                in_acc;
    logic                store_h0, store_h1, load_delta;
    logic                det_load, res_load, out_load;

    ttb_pkg::mac_ctrl_t  mac_ctrl;
    logic signed [D-1:0] mac_a, mac_b;
    logic                mac_done;
    logic signed [W-1:0] mac_acc;
    logic                div_start;
    logic                div_done;
    logic [QW-1:0]       div_quot;

    function automatic logic signed [D-1:0] delta(input logic signed [C-1:0] x,
                                                  input logic signed [C-1:0] y);
        delta = $signed({x[C-1], x}) - $signed({y[C-1], y});
    endfunction

    assign cur[0] = pos_x;
    assign cur[1] = pos_y;
    assign cur[2] = pos_z;
    assign cur[3] = tex_u;
    assign cur[4] = tex_v;

    assign in_ready = (state_reg == ttb_pkg::ST_IDLE);
    assign in_acc   = in_valid && in_ready;

    // Operand pair for the current product: det first, then tangent and
    // bitangent numerators, each as a first product less a second.
    always_comb
    begin
        mac_a = du1_reg;
        mac_b = dv2_reg;
        unique case (k_reg) inside
            3'd0:
            begin
                mac_a = ph_reg ? dv1_reg : du1_reg;
                mac_b = ph_reg ? du2_reg : dv2_reg;
            end
            [3'd1:3'd3]:
            begin
                mac_a = ph_reg ? dp2_reg[2'(k_reg - 3'd1)] : dp1_reg[2'(k_reg - 3'd1)];
                mac_b = ph_reg ? dv1_reg : dv2_reg;
            end
            [3'd4:3'd6]:
            begin
                mac_a = ph_reg ? dp1_reg[2'(k_reg - 3'd4)] : dp2_reg[2'(k_reg - 3'd4)];
                mac_b = ph_reg ? du2_reg : du1_reg;
            end
            default:
            begin
                mac_a = du1_reg;
                mac_b = dv2_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        k_next     = k_reg;
        ph_next    = ph_reg;
        degen_next = degen_reg;
        ov_next    = ov_reg;
        store_h0   = 1'b0;
        store_h1   = 1'b0;
        load_delta = 1'b0;
        det_load   = 1'b0;
        res_load   = 1'b0;
        out_load   = 1'b0;
        mac_ctrl   = '0;
        div_start  = 1'b0;

        if (ov_reg && out_ready)
            ov_next = 1'b0;

        unique case (state_reg)
            ttb_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (count_reg == 2'd2)
                    begin
                        load_delta = 1'b1;
                        count_next = 2'd0;
                        k_next     = 3'd0;
                        ph_next    = 1'b0;
                        degen_next = 1'b0;
                        state_next = ttb_pkg::ST_MAC_GO;
                    end
                    else if (count_reg == 2'd1)
                    begin
                        store_h1   = 1'b1;
                        count_next = 2'd2;
                    end
                    else
                    begin
                        store_h0   = 1'b1;
                        count_next = 2'd1;
                    end
                end
            end
            ttb_pkg::ST_MAC_GO:
            begin
                mac_ctrl.start = 1'b1;
                mac_ctrl.clear = !ph_reg;
                mac_ctrl.sub   = ph_reg;
                state_next     = ttb_pkg::ST_MAC_WAIT;
            end
            ttb_pkg::ST_MAC_WAIT:
            begin
                if (mac_done)
                begin
                    if (!ph_reg)
                    begin
                        ph_next    = 1'b1;
                        state_next = ttb_pkg::ST_MAC_GO;
                    end
                    else
                    begin
                        ph_next = 1'b0;
                        if (k_reg == 3'd0)
                        begin
                            det_load = 1'b1;
                            if (mac_acc == '0)
                            begin
                                degen_next = 1'b1;
                                state_next = ttb_pkg::ST_FIN;
                            end
                            else
                            begin
                                k_next     = 3'd1;
                                state_next = ttb_pkg::ST_MAC_GO;
                            end
                        end
                        else
                        begin
                            state_next = ttb_pkg::ST_DIV_GO;
                        end
                    end
                end
            end
            ttb_pkg::ST_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = ttb_pkg::ST_DIV_WAIT;
            end
            ttb_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    res_load = 1'b1;
                    if (k_reg == 3'd6)
                        state_next = ttb_pkg::ST_FIN;
                    else
                    begin
                        k_next     = k_reg + 3'd1;
                        state_next = ttb_pkg::ST_MAC_GO;
                    end
                end
            end
            ttb_pkg::ST_FIN:
            begin
                // Wait until the output word is free before overwriting it.
                if (!ov_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    ov_next    = 1'b1;
                    state_next = ttb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ttb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ttb_pkg::ST_IDLE;
            count_reg <= 2'd0;
            k_reg     <= 3'd0;
            ph_reg    <= 1'b0;
            degen_reg <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            k_reg     <= k_next;
            ph_reg    <= ph_next;
            degen_reg <= degen_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_h0)
            h0_reg <= cur;
        if (store_h1)
            h1_reg <= cur;
        if (load_delta)
        begin
            for (int j = 0; j < 3; j++)
            begin
                dp1_reg[j] <= delta(h1_reg[j], h0_reg[j]);
                dp2_reg[j] <= delta(cur[j], h0_reg[j]);
            end
            du1_reg <= delta(h1_reg[3], h0_reg[3]);
            dv1_reg <= delta(h1_reg[4], h0_reg[4]);
            du2_reg <= delta(cur[3], h0_reg[3]);
            dv2_reg <= delta(cur[4], h0_reg[4]);
        end
        if (det_load)
            det_reg <= mac_acc;
        if (res_load)
            res_reg[k_reg - 3'd1] <= div_quot;
        if (out_load)
        begin
            for (int j = 0; j < 6; j++)
                ow_reg[j] <= degen_reg ? '0 : res_reg[j];
        end
    end

    // The degenerate flag is a control bit and must be valid from reset.
    logic dg_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dg_reg <= 1'b0;
        else if (out_load)
            dg_reg <= degen_reg;
    end

    ttb_mac #(
        .D (D),
        .W (W)
    ) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mac_ctrl),
        .a     (mac_a),
        .b     (mac_b),
        .done  (mac_done),
        .acc   (mac_acc)
    );

    ttb_div #(
        .W (W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (mac_acc),
        .den   (det_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign out_valid   = ov_reg;
    assign tangent_x   = $signed(ow_reg[0]);
    assign tangent_y   = $signed(ow_reg[1]);
    assign tangent_z   = $signed(ow_reg[2]);
    assign bitangent_x = $signed(ow_reg[3]);
    assign bitangent_y = $signed(ow_reg[4]);
    assign bitangent_z = $signed(ow_reg[5]);
    assign degenerate  = dg_reg;

endmodule

`default_nettype wire

[rtl/ttb_mac.sv]
// ----------------------------------------------------------------------------
// ttb_mac: bit-serial signed multiply-accumulate
// Adds or subtracts a*b into the accumulator, taking one bit of |b| per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ttb_mac #(
    parameter int D = 17,
    parameter int W = 34
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ttb_pkg::mac_ctrl_t  ctrl,
    input  wire logic signed [D-1:0] a,
    input  wire logic signed [D-1:0] b,
    output logic                     done,
    output logic signed [W-1:0]      acc
);

    localparam int CW = $clog2(D);

    logic signed [W-1:0] acc_reg, acc_next;
    logic [W-1:0]        m_reg, m_next;
    logic [D-1:0]        b_reg, b_next;
    logic                neg_reg, neg_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [W-1:0]        addend;

    always_comb
    begin
        acc_next  = acc_reg;
        m_next    = m_reg;
        b_next    = b_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        // Negation is invert plus one; the increment and the accumulate are separate adds.
        addend = b_reg[0] ? ((m_reg ^ {W{neg_reg}}) + W'(neg_reg)) : '0;
        if (ctrl.start)
        begin
            acc_next  = ctrl.clear ? '0 : acc_reg;
            m_next    = {{(W-D){a[D-1]}}, a};
            b_next    = b[D-1] ? (~b + D'(1)) : b;
            neg_next  = b[D-1] ^ ctrl.sub;
            cnt_next  = CW'(D - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = acc_reg + $signed(addend);
            m_next   = {m_reg[W-2:0], 1'b0};
            b_next   = {1'b0, b_reg[D-1:1]};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        m_reg   <= m_next;
        b_reg   <= b_next;
        neg_reg <= neg_next;
    end

    assign done = done_reg;
    assign acc  = acc_reg;

endmodule

`default_nettype wire

[rtl/ttb_div.sv]
// ----------------------------------------------------------------------------
// ttb_div: bit-serial restoring divider with Q15.16 saturation
// Produces num/den in Q15.16, truncated toward zero, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ttb_div #(
    parameter int W = 34
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic signed [W-1:0]        num,
    input  wire logic signed [W-1:0]        den,
    output logic                            done,
    output logic [ttb_pkg::OUT_W-1:0]       quot
);

    localparam int QW = ttb_pkg::OUT_W;
    localparam int NW = W + ttb_pkg::Q_FRAC;
    localparam int CW = $clog2(NW);

    logic [NW-1:0] n_reg, n_next;
    logic [W-1:0]  r_reg, r_next;
    logic [W-1:0]  d_reg, d_next;
    logic [QW-1:0] q_reg, q_next;
    logic          ovf_reg, ovf_next;
    logic          neg_reg, neg_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    trial;
    logic [W:0]    diff;
    logic          ge;
    logic [W-1:0]  num_mag;
    logic [W-1:0]  den_mag;
    logic [QW:0]   q_mag;

    always_comb
    begin
        num_mag = num[W-1] ? (~num + W'(1)) : num;
        den_mag = den[W-1] ? (~den + W'(1)) : den;
        trial   = {r_reg, n_reg[NW-1]};
        diff    = trial - {1'b0, d_reg};
        ge      = (trial >= {1'b0, d_reg});

        n_next    = n_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        q_next    = q_reg;
        ovf_next  = ovf_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            n_next    = {num_mag, {ttb_pkg::Q_FRAC{1'b0}}};
            r_next    = '0;
            d_next    = den_mag;
            q_next    = '0;
            ovf_next  = 1'b0;
            neg_next  = num[W-1] ^ den[W-1];
            cnt_next  = CW'(NW - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            n_next   = {n_reg[NW-2:0], 1'b0};
            r_next   = ge ? diff[W-1:0] : trial[W-1:0];
            // Any quotient bit beyond the 32-bit field means saturation.
            ovf_next = ovf_reg | q_reg[QW-1];
            q_next   = {q_reg[QW-2:0], ge};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        q_reg   <= q_next;
        ovf_reg <= ovf_next;
        neg_reg <= neg_next;
    end

    always_comb
    begin
        q_mag = ovf_reg ? {1'b1, {QW{1'b0}}} : {1'b0, q_reg};
        if (!neg_reg)
        begin
            if (q_mag > {1'b0, 1'b0, {(QW-1){1'b1}}})
                quot = {1'b0, {(QW-1){1'b1}}};
            else
                quot = q_mag[QW-1:0];
        end
        else
        begin
            if (q_mag > {1'b0, 1'b1, {(QW-1){1'b0}}})
                quot = {1'b1, {(QW-1){1'b0}}};
            else
                quot = ~q_mag[QW-1:0] + QW'(1);
        end
    end

    assign done = done_reg;

endmodule

`default_nettype wire

[verif/tb_triangle_tangent_basis.sv]
// ----------------------------------------------------------------------------
// tb_triangle_tangent_basis: self-checking bench for the tangent basis block
// Streams triangle corners through the block under several idling patterns,
// predicts each tangent and bitangent word with exact wide arithmetic and
// compares every field of every result word against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_triangle_tangent_basis;

    localparam int  CW         = 16;
    localparam int  TAIL_WAIT  = 800;
    localparam longint CYCLE_LIMIT = 3_000_000;

    typedef struct {
        logic signed [CW-1:0] px, py, pz, u, v;
    } corner_t;

    typedef struct {
        logic signed [31:0] tx, ty, tz, bx, by, bz;
        logic               degen;
    } basis_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [CW-1:0] pos_x = '0, pos_y = '0, pos_z = '0, tex_u = '0, tex_v = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [31:0] tangent_x, tangent_y, tangent_z;
    logic signed [31:0] bitangent_x, bitangent_y, bitangent_z;
    logic degenerate;

    triangle_tangent_basis #(.COORD_BITS(CW)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .tex_u(tex_u), .tex_v(tex_v),
        .out_valid(out_valid), .out_ready(out_ready),
        .tangent_x(tangent_x), .tangent_y(tangent_y), .tangent_z(tangent_z),
        .bitangent_x(bitangent_x), .bitangent_y(bitangent_y), .bitangent_z(bitangent_z),
        .degenerate(degenerate)
    );

    // Predictor state: the corners held so far for the current triangle.
    corner_t held[2];
    int      held_count = 0;
    basis_t  pending_basis[$];

    int  fail_count = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  recv_hold = 0;
    longint cycle_count = 0;

    initial begin
        forever #4 clk = ~clk;
    end

    initial begin
        forever begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Exact quotient in Q15.16, truncated toward zero, saturated.
    function automatic logic signed [31:0] q16_quotient(longint num, longint den);
        longint q;
        q = (num * 65536) / den;
        if (q > 64'sh7FFFFFFF)
            return 32'sh7FFFFFFF;
        if (q < -64'sh80000000)
            return 32'h80000000;
        return q[31:0];
    endfunction

    function automatic void predict_corner(corner_t c);
        longint dp1[3], dp2[3], du1, dv1, du2, dv2, det, tn, bn;
        longint p0[3], p1[3], p2[3];
        basis_t r;
        if (held_count < 2) begin
            held[held_count] = c;
            held_count++;
            return;
        end
        held_count = 0;
        p0 = '{held[0].px, held[0].py, held[0].pz};
        p1 = '{held[1].px, held[1].py, held[1].pz};
        p2 = '{c.px, c.py, c.pz};
        for (int j = 0; j < 3; j++) begin
            dp1[j] = p1[j] - p0[j];
            dp2[j] = p2[j] - p0[j];
        end
        du1 = longint'(held[1].u) - held[0].u;
        dv1 = longint'(held[1].v) - held[0].v;
        du2 = longint'(c.u) - held[0].u;
        dv2 = longint'(c.v) - held[0].v;
        det = du1 * dv2 - dv1 * du2;
        r = '{default: 0};
        if (det == 0) begin
            r.degen = 1'b1;
        end else begin
            logic signed [31:0] t[3], b[3];
            for (int j = 0; j < 3; j++) begin
                tn = dp1[j] * dv2 - dp2[j] * dv1;
                bn = dp2[j] * du1 - dp1[j] * du2;
                t[j] = q16_quotient(tn, det);
                b[j] = q16_quotient(bn, det);
            end
            r.tx = t[0]; r.ty = t[1]; r.tz = t[2];
            r.bx = b[0]; r.by = b[1]; r.bz = b[2];
            r.degen = 1'b0;
        end
        pending_basis = {pending_basis, r};
    endfunction

    // Accepted corners feed the predictor; accepted results are checked.
    initial begin
        basis_t e;
        forever begin
            @(posedge clk);
            if (rst_n && in_valid && in_ready)
                predict_corner('{pos_x, pos_y, pos_z, tex_u, tex_v});
            if (rst_n && out_valid && out_ready) begin
                if (pending_basis.size() == 0) begin
                    $error("unexpected result word");
                    fail_count++;
                end else begin
                    e = pending_basis.pop_front();
                    if (tangent_x !== e.tx) begin
                        $error("tangent_x expected %0d got %0d", e.tx, tangent_x); fail_count++;
                    end
                    if (tangent_y !== e.ty) begin
                        $error("tangent_y expected %0d got %0d", e.ty, tangent_y); fail_count++;
                    end
                    if (tangent_z !== e.tz) begin
                        $error("tangent_z expected %0d got %0d", e.tz, tangent_z); fail_count++;
                    end
                    if (bitangent_x !== e.bx) begin
                        $error("bitangent_x expected %0d got %0d", e.bx, bitangent_x);
                        fail_count++;
                    end
                    if (bitangent_y !== e.by) begin
                        $error("bitangent_y expected %0d got %0d", e.by, bitangent_y);
                        fail_count++;
                    end
                    if (bitangent_z !== e.bz) begin
                        $error("bitangent_z expected %0d got %0d", e.bz, bitangent_z);
                        fail_count++;
                    end
                    if (degenerate !== e.degen) begin
                        $error("degenerate expected %0d got %0d", e.degen, degenerate);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off while recv_hold is set.
    initial begin
        forever begin
            @(negedge clk);
            if (recv_hold > 0) begin
                recv_hold--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_corner(corner_t c);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        pos_x <= c.px; pos_y <= c.py; pos_z <= c.pz; tex_u <= c.u; tex_v <= c.v;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_basis.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    function automatic logic signed [CW-1:0] rnd16();
        return CW'($urandom());
    endfunction

    function automatic logic signed [CW-1:0] near(int base, int span);
        return CW'(base + $urandom_range(2 * span) - span);
    endfunction

    // Kinds: ordinary random, compact, degenerate UVs, tiny UVs with far positions.
    task automatic send_triangle(int kind);
        corner_t c[3];
        int u0, v0, du, dv, k;
        for (int i = 0; i < 3; i++)
            c[i] = '{rnd16(), rnd16(), rnd16(), rnd16(), rnd16()};
        case (kind)
            1: begin
                u0 = $urandom_range(16000) - 8000;
                v0 = $urandom_range(16000) - 8000;
                for (int i = 0; i < 3; i++) begin
                    c[i].px = near(0, 4096); c[i].py = near(0, 4096); c[i].pz = near(0, 4096);
                    c[i].u = near(u0, 2000); c[i].v = near(v0, 2000);
                end
            end
            2: begin
                u0 = $urandom_range(16000) - 8000;
                v0 = $urandom_range(16000) - 8000;
                du = $urandom_range(2000) - 1000;
                dv = $urandom_range(2000) - 1000;
                k = $urandom_range(6) - 3;
                c[0].u = CW'(u0); c[0].v = CW'(v0);
                c[1].u = CW'(u0 + du); c[1].v = CW'(v0 + dv);
                c[2].u = CW'(u0 + k * du); c[2].v = CW'(v0 + k * dv);
            end
            3: begin
                u0 = rnd16(); v0 = rnd16();
                for (int i = 0; i < 3; i++) begin
                    c[i].u = CW'(u0 + $urandom_range(2));
                    c[i].v = CW'(v0 + $urandom_range(2));
                end
            end
            default: ;
        endcase
        for (int i = 0; i < 3; i++)
            send_corner(c[i]);
    endtask

    task automatic test_directed();
        localparam logic signed [CW-1:0] MX = 16'sh7FFF;
        localparam logic signed [CW-1:0] MN = 16'sh8000;
        // Unit right triangle: tangent along x, bitangent along y.
        send_corner('{0, 0, 0, 0, 0});
        send_corner('{16'sd4096, 0, 0, 16'sd4096, 0});
        send_corner('{0, 16'sd4096, 0, 0, 16'sd4096});
        // Identical UVs give a zero determinant.
        send_corner('{MX, MN, MX, 16'sd5, 16'sd5});
        send_corner('{MN, MX, MN, 16'sd5, 16'sd5});
        send_corner('{MX, MX, MX, 16'sd5, 16'sd5});
        // Full-range positions over a one-step UV triangle saturate both ways.
        send_corner('{MN, MN, MN, 0, 0});
        send_corner('{MX, MN, MX, 16'sd1, 0});
        send_corner('{MN, MX, MX, 0, 16'sd1});
        send_corner('{MX, MX, MN, 0, 0});
        send_corner('{MN, MN, MX, 16'sd1, 0});
        send_corner('{MX, MN, MN, 0, -16'sd1});
        // Extreme UV corners with extreme positions.
        send_corner('{MN, MX, 0, MN, MN});
        send_corner('{MX, MN, 0, MX, MN});
        send_corner('{0, 0, MX, MN, MX});
        send_corner('{MX, MX, MX, MX, MX});
        send_corner('{MN, MN, MN, MN, MN});
        send_corner('{-16'sd1, -16'sd1, -16'sd1, MX, MN});
        // Collinear UVs: degenerate without repeated corners.
        send_corner('{16'sd100, 16'sd200, 16'sd300, 16'sd10, 16'sd20});
        send_corner('{16'sd400, 16'sd500, 16'sd600, 16'sd20, 16'sd40});
        send_corner('{16'sd700, 16'sd800, 16'sd900, 16'sd40, 16'sd80});
        wait_drained();
    endtask

    task automatic test_random_phase(int idle_pct, int stall_pct, int triangles);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < triangles; n++)
            send_triangle($urandom_range(9) < 5 ? 0 : $urandom_range(3));
        wait_drained();
    endtask

    task automatic test_long_holdoff();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        recv_hold = 3000;
        for (int n = 0; n < 8; n++)
            send_triangle($urandom_range(3));
        wait_drained();
    endtask

    initial begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_random_phase(0, 0, 90);
        test_random_phase(62, 0, 90);
        test_random_phase(0, 62, 90);
        test_random_phase(34, 34, 90);
        test_long_holdoff();
        test_random_phase($urandom_range(50), $urandom_range(50), 12);
        in_valid <= 1'b0;
        while (pending_basis.size() != 0) @(negedge clk);
        repeat (TAIL_WAIT) @(negedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[files.f]
rtl/ttb_pkg.sv
rtl/ttb_mac.sv
rtl/ttb_div.sv
rtl/triangle_tangent_basis.sv
verif/tb_triangle_tangent_basis.sv
